[rtl/dq_pkg.sv]
package dq_pkg;

    // Operation codes carried in the kind field of an input word
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_REAR   = 3'd3;
    localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;
    localparam logic [2:0] KIND_SEARCH     = 3'd6;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    // Data movement along the cell row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN,
        OP_LOAD_REAR
    } t_cell_op;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        t_cell_op op;
        logic     tok_start;
        logic     tok_shift;
        logic     tok_clear;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

[rtl/dq_cell.sv]
module dq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dq_pkg::t_cell_ctl         i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic [dq_pkg::DATA_W-1:0] i_value,
    input  logic [dq_pkg::DATA_W-1:0] i_key,
    input  logic [dq_pkg::DATA_W-1:0] i_lower,
    input  logic [dq_pkg::DATA_W-1:0] i_upper,
    input  logic                      i_tok,
    output logic [dq_pkg::DATA_W-1:0] o_data,
    output logic [dq_pkg::DATA_W-1:0] o_rear_part,
    output logic                      o_tok,
    output logic                      o_hit
);

    logic [dq_pkg::DATA_W-1:0] r_data;
    logic [dq_pkg::DATA_W-1:0] n_data;
    logic                      r_tok;
    logic                      n_tok;
    logic                      w_last;

    // Pick the next element held in this cell
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            dq_pkg::OP_HOLD:       n_data = r_data;
            dq_pkg::OP_SHIFT_UP:   n_data = i_lower;
            dq_pkg::OP_SHIFT_DOWN: n_data = i_upper;
            dq_pkg::OP_LOAD_REAR: begin
                if (i_count == CW'(IDX)) begin
                    n_data = i_value;
                end
            end
            default:               n_data = r_data;
        endcase
    end

    // Advance the search token one cell per cycle
    always_comb begin
        n_tok = r_tok;
        if (i_ctl.tok_start) begin
            n_tok = (IDX == 0);
        end else if (i_ctl.tok_shift) begin
            n_tok = i_tok;
        end else if (i_ctl.tok_clear) begin
            n_tok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // This cell holds the rear element when it is the last occupied one
    assign w_last      = (i_count == CW'(IDX + 1));
    assign o_data      = r_data;
    assign o_rear_part = w_last ? r_data : '0;
    assign o_tok       = r_tok;
    assign o_hit       = r_tok && (r_data == i_key);

endmodule

[rtl/dq_chain.sv]
module dq_chain #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dq_pkg::t_cell_ctl         i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic [dq_pkg::DATA_W-1:0] i_value,
    input  logic [dq_pkg::DATA_W-1:0] i_key,
    output logic [dq_pkg::DATA_W-1:0] o_front,
    output logic [dq_pkg::DATA_W-1:0] o_rear,
    output logic                      o_hit
);

    logic [dq_pkg::DATA_W-1:0] w_data [DEPTH];
    logic [dq_pkg::DATA_W-1:0] w_rear [DEPTH];
    logic                      w_tok  [DEPTH];
    logic                      w_hit  [DEPTH];

    // Build the row: cell 0 is the front of the queue
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [dq_pkg::DATA_W-1:0] w_lower;
        logic [dq_pkg::DATA_W-1:0] w_upper;
        logic                      w_tok_in;

        if (g == 0) begin : g_first
            assign w_lower  = i_value;
            assign w_tok_in = 1'b0;
        end else begin : g_mid
            assign w_lower  = w_data[g-1];
            assign w_tok_in = w_tok[g-1];
        end

        if (g == DEPTH - 1) begin : g_top
            assign w_upper = w_data[g];
        end else begin : g_below
            assign w_upper = w_data[g+1];
        end

        dq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_count     (i_count),
            .i_value     (i_value),
            .i_key       (i_key),
            .i_lower     (w_lower),
            .i_upper     (w_upper),
            .i_tok       (w_tok_in),
            .o_data      (w_data[g]),
            .o_rear_part (w_rear[g]),
            .o_tok       (w_tok[g]),
            .o_hit       (w_hit[g])
        );
    end

    // Merge the rear element and the compare hit from all cells
    always_comb begin
        o_rear = '0;
        o_hit  = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            o_rear = o_rear | w_rear[k];
            o_hit  = o_hit | w_hit[k];
        end
    end

    assign o_front = w_data[0];

endmodule

[rtl/ring_buffer_deque_top.sv]
// Channel  | Handshake           | Fields
// ---------+---------------------+-------------------------------------------
// input    | i_valid / o_stall   | i_kind, i_value
// output   | o_valid / i_stall   | o_data_out, o_status, o_found_position,
//          |                     | o_occupancy
//
// Push, pop and peek words are done in ST_IDLE; the next word is taken at once unless the output word is held.
// A search walks a token up the cell row one cell per cycle, from the front
// until it hits the key or reaches the rear element.
// The input is stalled while a search runs or the output word is held.
// Reset is synchronous and empties the queue; no clearing pass is needed.
module ring_buffer_deque_top #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [2:0]                       i_kind,
    input  logic signed [dq_pkg::DATA_W-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [dq_pkg::DATA_W-1:0] o_data_out,
    output logic [1:0]                       o_status,
    output logic [dq_pkg::POS_W-1:0]         o_found_position,
    output logic [dq_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    dq_pkg::t_state            r_state;
    dq_pkg::t_state            n_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             n_idx;
    logic [dq_pkg::DATA_W-1:0] r_key;

    logic                      r_ovalid;
    logic [dq_pkg::DATA_W-1:0] r_data;
    logic [1:0]                r_status;
    logic [dq_pkg::POS_W-1:0]  r_pos;
    logic [dq_pkg::OCC_W-1:0]  r_occ;

    logic                      w_out_free;
    logic                      w_in_acc;
    logic                      w_load;
    logic [dq_pkg::DATA_W-1:0] w_ld_data;
    logic [1:0]                w_ld_status;
    logic [dq_pkg::POS_W-1:0]  w_ld_pos;
    logic                      w_key_load;
    logic                      w_scan_end;
    dq_pkg::t_cell_ctl         w_ctl;
    logic [dq_pkg::DATA_W-1:0] w_front;
    logic [dq_pkg::DATA_W-1:0] w_rear;
    logic                      w_hit;
    logic [31:0]               w_idx_ext;
    logic [31:0]               w_occ_ext;
    logic                      w_empty;
    logic                      w_full;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = !((r_state == dq_pkg::ST_IDLE) && w_out_free);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_scan_end = w_hit || ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_idx_ext  = 32'(r_idx);
    assign w_occ_ext  = 32'(n_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (w_in_acc && (i_kind == dq_pkg::KIND_SEARCH) && !w_empty) begin
                    n_state = dq_pkg::ST_SCAN;
                end
            end
            dq_pkg::ST_SCAN: begin
                if (w_scan_end && w_out_free) begin
                    n_state = dq_pkg::ST_IDLE;
                end
            end
            default: n_state = dq_pkg::ST_IDLE;
        endcase
    end

    // Decode the word into cell moves, count update and result
    always_comb begin
        w_ctl       = '{op: dq_pkg::OP_HOLD, tok_start: 1'b0,
                        tok_shift: 1'b0, tok_clear: 1'b0};
        n_count     = r_count;
        n_idx       = r_idx;
        w_load      = 1'b0;
        w_ld_data   = '0;
        w_ld_status = dq_pkg::STATUS_OK;
        w_ld_pos    = '0;
        w_key_load  = 1'b0;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    w_load = 1'b1;
                    case (i_kind)
                        dq_pkg::KIND_PUSH_FRONT,
                        dq_pkg::KIND_PUSH_REAR: begin
                            if (w_full) begin
                                w_ld_status = dq_pkg::STATUS_FULL;
                            end else begin
                                w_ctl.op = (i_kind == dq_pkg::KIND_PUSH_FRONT) ?
                                           dq_pkg::OP_SHIFT_UP : dq_pkg::OP_LOAD_REAR;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        dq_pkg::KIND_POP_FRONT: begin
                            if (w_empty) begin
                                w_ld_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                w_ld_data = w_front;
                                w_ctl.op  = dq_pkg::OP_SHIFT_DOWN;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        dq_pkg::KIND_POP_REAR: begin
                            if (w_empty) begin
                                w_ld_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                w_ld_data = w_rear;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        dq_pkg::KIND_PEEK_FRONT,
                        dq_pkg::KIND_PEEK_REAR: begin
                            if (w_empty) begin
                                w_ld_status = dq_pkg::STATUS_EMPTY;
                            end else begin
                                w_ld_data = (i_kind == dq_pkg::KIND_PEEK_FRONT) ?
                                            w_front : w_rear;
                            end
                        end
                        dq_pkg::KIND_SEARCH: begin
                            if (w_empty) begin
                                w_ld_status = dq_pkg::STATUS_NOT_FOUND;
                            end else begin
                                w_load          = 1'b0;
                                w_key_load      = 1'b1;
                                w_ctl.tok_start = 1'b1;
                                n_idx           = '0;
                            end
                        end
                        default: begin
                            w_ld_status = dq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            dq_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    if (w_out_free) begin
                        w_load          = 1'b1;
                        w_ctl.tok_clear = 1'b1;
                        if (w_hit) begin
                            w_ld_pos = w_idx_ext[dq_pkg::POS_W-1:0];
                        end else begin
                            w_ld_status = dq_pkg::STATUS_NOT_FOUND;
                        end
                    end
                end else begin
                    w_ctl.tok_shift = 1'b1;
                    n_idx           = r_idx + IW'(1);
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    dq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_count (r_count),
        .i_value (i_value),
        .i_key   (r_key),
        .o_front (w_front),
        .o_rear  (w_rear),
        .o_hit   (w_hit)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dq_pkg::ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Hold the search key and the result word
    always_ff @(posedge i_clk) begin
        if (w_key_load) begin
            r_key <= i_value;
        end
        if (w_load) begin
            r_data   <= w_ld_data;
            r_status <= w_ld_status;
            r_pos    <= w_ld_pos;
            r_occ    <= w_occ_ext[dq_pkg::OCC_W-1:0];
        end
    end

    assign o_valid          = r_ovalid;
    assign o_data_out       = r_data;
    assign o_status         = r_status;
    assign o_found_position = r_pos;
    assign o_occupancy      = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above capacity");

    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::ST_SCAN) |-> o_stall)
        else $error("input taken during search");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::ST_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("search token past rear element");

    a_search_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == dq_pkg::KIND_SEARCH) && !w_empty)
        |=> (r_state == dq_pkg::ST_SCAN))
        else $error("search did not start scan");

endmodule
